/* rtl/mnsq_pkg.sv */
// Shared types and constants of the MIDI note scale quantiser.
package mnsq_pkg;

	localparam int KEY_W    = 7;
	localparam int VEL_W    = 7;
	localparam int STATUS_W = 8;
	localparam int TICK_W   = 32;
	localparam int NOTES    = 128;
	localparam int NOTE_COUNT = 127;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWEST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHEST   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_OFS  = 3'd5;

	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

	localparam logic [KEY_W-1:0] KEY_MIN = 7'd24;
	localparam logic [KEY_W-1:0] KEY_MAX = 7'd127;

	localparam logic [KEY_W-1:0] LOWEST_RST  = 7'd21;
	localparam logic [KEY_W-1:0] HIGHEST_RST = 7'd126;

	typedef struct packed {
		logic [63:0]       mask_low;
		logic [62:0]       mask_high;
		logic [KEY_W-1:0]  lowest;
		logic [KEY_W-1:0]  highest;
		logic [7:0]        transpose;
		logic [TICK_W-1:0] tick_offset;
	} cfg_t;

endpackage

/* rtl/midi_note_scale_quantizer.sv */
// Top level of the MIDI note scale quantiser: input stage, key path and result stage.
//
//  group  direction  payload                                         request when
//  s_*    in         tuser status; tdata key, velocity, tick         tvalid & tready
//  m_*    out        tuser status; tdata key, velocity, tick         tvalid & tready
//  cfg_*  in         cfg_index register, cfg_data value              cfg_valid & cfg_ready
//
// One request can enter every cycle while s_tready is high; note events pass both stages.
// Events other than note-on and note-off are dropped in the input stage and give no result.
// The input register and the result register form a two-deep pipeline, so s_tready stays high
// while a result waits, unless both stages are full and m_tready is low.
// Reset clears both stages and loads the register defaults; no clearing pass is needed.
module midi_note_scale_quantizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // note_key, note_velocity, event_tick, pad
	input  logic [7:0]                      s_tuser,  // status_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,  // out_key, out_velocity, out_tick, pad
	output logic [7:0]                      m_tuser,  // out_status
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mnsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mnsq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mnsq_pkg::*;

	cfg_t cfg;

	logic                v_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [VEL_W-1:0]    vel_s1;
	logic [TICK_W-1:0]   tick_s1;

	logic                v_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [KEY_W-1:0]    key_s2;
	logic [VEL_W-1:0]    vel_s2;
	logic [TICK_W-1:0]   tick_s2;

	logic                s2_free;
	logic                in_note;
	logic [3:0]          in_cmd;
	logic [KEY_W-1:0]    key_snap;
	logic [STATUS_W-1:0] status_new;

	mnsq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mnsq_snap u_snap (
		.key_in  (key_s1),
		.cfg     (cfg),
		.key_out (key_snap)
	);

	assign s2_free  = !v_s2 || m_tready;
	assign s_tready = !v_s1 || s2_free;
	assign in_cmd   = s_tuser[7:4];
	assign in_note  = (in_cmd == CMD_NOTE_ON) || (in_cmd == CMD_NOTE_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid && in_note;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			status_s1 <= s_tuser;
			key_s1    <= s_tdata[6:0];
			vel_s1    <= s_tdata[13:7];
			tick_s1   <= s_tdata[45:14];
		end
	end

	// A zero velocity turns either note command into note-off on the same channel.
	assign status_new = (vel_s1 == '0) ? {CMD_NOTE_OFF, status_s1[3:0]} : status_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			status_s2 <= status_new;
			key_s2    <= key_snap;
			vel_s2    <= vel_s1;
			tick_s2   <= tick_s1 + cfg.tick_offset;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {2'b00, tick_s2, vel_s2, key_s2};

endmodule

/* rtl/mnsq_cfg.sv */
// Configuration register file of the MIDI note scale quantiser.
module mnsq_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mnsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mnsq_pkg::CFG_DATA_W-1:0] cfg_data,
	output mnsq_pkg::cfg_t                  cfg
);
	import mnsq_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mask_low    <= '0;
			cfg_q.mask_high   <= '0;
			cfg_q.lowest      <= LOWEST_RST;
			cfg_q.highest     <= HIGHEST_RST;
			cfg_q.transpose   <= '0;
			cfg_q.tick_offset <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MASK_LOW:  cfg_q.mask_low    <= cfg_data;
				REG_MASK_HIGH: cfg_q.mask_high   <= cfg_data[62:0];
				REG_LOWEST:    cfg_q.lowest      <= cfg_data[KEY_W-1:0];
				REG_HIGHEST:   cfg_q.highest     <= cfg_data[KEY_W-1:0];
				REG_TRANSPOSE: cfg_q.transpose   <= cfg_data[7:0];
				REG_TICK_OFS:  cfg_q.tick_offset <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/mnsq_snap.sv */
// Key path: transpose, range clamp, limit to the lowest and highest registers and snap to the nearest scale note.
module mnsq_snap (
	input  logic [mnsq_pkg::KEY_W-1:0] key_in,
	input  mnsq_pkg::cfg_t             cfg,
	output logic [mnsq_pkg::KEY_W-1:0] key_out
);
	import mnsq_pkg::*;

	logic signed [KEY_W+1:0] sum;
	logic [KEY_W-1:0]        clamped;
	logic [NOTES-1:0]        scale;
	logic [NOTES-1:0]        up_vec;
	logic [NOTES-1:0]        dn_vec;
	logic [KEY_W-1:0]        up_idx;
	logic [KEY_W-1:0]        dn_idx;
	logic                    up_found;
	logic                    dn_found;
	logic [KEY_W-1:0]        up_dist;
	logic [KEY_W-1:0]        dn_dist;

	always_comb begin
		sum = $signed({2'b00, key_in}) + $signed({cfg.transpose[7], cfg.transpose});
		if (sum > $signed({2'b00, KEY_MAX})) begin
			clamped = KEY_MAX;
		end else if (sum < $signed({2'b00, KEY_MIN})) begin
			clamped = KEY_MIN;
		end else begin
			clamped = sum[KEY_W-1:0];
		end
	end

	// Notes at or above the note count are never part of the scale.
	always_comb begin
		for (int i = 0; i < NOTES; i++) begin
			if (i >= NOTE_COUNT) begin
				scale[i] = 1'b0;
			end else if (i < 64) begin
				scale[i] = cfg.mask_low[i];
			end else begin
				scale[i] = cfg.mask_high[i-64];
			end
		end
	end

	assign up_vec = scale & ({NOTES{1'b1}} << clamped);
	assign dn_vec = scale & ~(({NOTES{1'b1}} << clamped) << 1);
	assign up_found = |up_vec;
	assign dn_found = |dn_vec;

	// Lowest set note at or above the key, and highest set note at or below it.
	always_comb begin
		up_idx = '0;
		for (int i = NOTES - 1; i >= 0; i--) begin
			if (up_vec[i]) begin
				up_idx = KEY_W'(i);
			end
		end
	end

	always_comb begin
		dn_idx = '0;
		for (int i = 0; i < NOTES; i++) begin
			if (dn_vec[i]) begin
				dn_idx = KEY_W'(i);
			end
		end
	end

	assign up_dist = up_idx - clamped;
	assign dn_dist = clamped - dn_idx;

	// The upper neighbour wins when both lie at the same distance.
	always_comb begin
		if (clamped >= cfg.highest) begin
			key_out = cfg.highest;
		end else if (clamped <= cfg.lowest) begin
			key_out = cfg.lowest;
		end else if (up_found && (!dn_found || up_dist <= dn_dist)) begin
			key_out = up_idx;
		end else if (dn_found) begin
			key_out = dn_idx;
		end else begin
			key_out = clamped;
		end
	end

endmodule

/* dv/midi_note_scale_quantizer_chk.sv */
// Checker of the MIDI note scale quantiser: tracks the registers, predicts each note and compares.
`timescale 1ns / 1ps

module midi_note_scale_quantizer_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // note_key, note_velocity, event_tick, pad
	input  logic [7:0]                      s_tuser,  // status_byte
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [47:0]                     m_tdata,  // out_key, out_velocity, out_tick, pad
	input  logic [7:0]                      m_tuser,  // out_status
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mnsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mnsq_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import mnsq_pkg::*;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key;
		logic [VEL_W-1:0]    velocity;
		logic [TICK_W-1:0]   tick;
	} note_evt_t;

	cfg_t      regs;
	note_evt_t pending_notes[$];

	function automatic bit note_in_scale(input int n, input cfg_t c);
		if (n < 0 || n >= NOTE_COUNT || n > 127)
			return 1'b0;
		if (n < 64)
			return c.mask_low[n];
		return c.mask_high[n-64];
	endfunction

	function automatic note_evt_t quantise_note(input logic [STATUS_W-1:0] status,
	                                            input logic [KEY_W-1:0] key,
	                                            input logic [VEL_W-1:0] velocity,
	                                            input logic [TICK_W-1:0] tick,
	                                            input cfg_t c);
		note_evt_t r;
		int        k;
		int        snapped;
		bit        found;
		k = int'(key) + int'($signed(c.transpose));
		if (k > int'(KEY_MAX))
			k = int'(KEY_MAX);
		if (k < int'(KEY_MIN))
			k = int'(KEY_MIN);
		// The highest bound is tested first, so crossed bounds favour it.
		if (k >= int'(c.highest)) begin
			snapped = int'(c.highest);
		end else if (k <= int'(c.lowest)) begin
			snapped = int'(c.lowest);
		end else begin
			snapped = k;
			found   = 1'b0;
			for (int d = 0; d <= 127 && !found; d++) begin
				if (note_in_scale(k + d, c)) begin
					snapped = k + d;
					found   = 1'b1;
				end else if (note_in_scale(k - d, c)) begin
					snapped = k - d;
					found   = 1'b1;
				end
			end
		end
		r.status   = (velocity == '0) ? {CMD_NOTE_OFF, status[3:0]} : status;
		r.key      = KEY_W'(snapped);
		r.velocity = velocity;
		r.tick     = tick + c.tick_offset;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		note_evt_t want;
		if (!arst_n) begin
			regs.mask_low    = '0;
			regs.mask_high   = '0;
			regs.lowest      = LOWEST_RST;
			regs.highest     = HIGHEST_RST;
			regs.transpose   = '0;
			regs.tick_offset = '0;
			pending_notes.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MASK_LOW:  regs.mask_low    = cfg_data;
					REG_MASK_HIGH: regs.mask_high   = cfg_data[62:0];
					REG_LOWEST:    regs.lowest      = cfg_data[KEY_W-1:0];
					REG_HIGHEST:   regs.highest     = cfg_data[KEY_W-1:0];
					REG_TRANSPOSE: regs.transpose   = cfg_data[7:0];
					REG_TICK_OFS:  regs.tick_offset = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			// Results are compared before this cycle's request is queued.
			if (m_tvalid && m_tready) begin
				if (pending_notes.size() == 0) begin
					$error("unexpected result: status %02h key %0d", m_tuser, m_tdata[6:0]);
					mismatches++;
				end else begin
					want = pending_notes.pop_front();
					if (m_tuser !== want.status) begin
						$error("out_status: expected %02h, actual %02h", want.status, m_tuser);
						mismatches++;
					end
					if (m_tdata[6:0] !== want.key) begin
						$error("out_key: expected %0d, actual %0d", want.key, m_tdata[6:0]);
						mismatches++;
					end
					if (m_tdata[13:7] !== want.velocity) begin
						$error("out_velocity: expected %0d, actual %0d", want.velocity,
						       m_tdata[13:7]);
						mismatches++;
					end
					if (m_tdata[45:14] !== want.tick) begin
						$error("out_tick: expected %08h, actual %08h", want.tick, m_tdata[45:14]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready &&
			    (s_tuser[7:4] == CMD_NOTE_ON || s_tuser[7:4] == CMD_NOTE_OFF))
				pending_notes.insert(pending_notes.size(),
				                     quantise_note(s_tuser, s_tdata[6:0], s_tdata[13:7],
				                                   s_tdata[45:14], regs));
		end
		outstanding = pending_notes.size();
	end

endmodule

/* dv/midi_note_scale_quantizer_tb.sv */
// Testbench top of the MIDI note scale quantiser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module midi_note_scale_quantizer_tb;
	import mnsq_pkg::*;

	// Indexes beyond the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [11:0]          MAJOR_CLASSES = 12'hAB5;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic [7:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [47:0]           m_tdata;
	logic [7:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	bit                    idle_on = 1'b1;
	int                    stall_left;

	midi_note_scale_quantizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	midi_note_scale_quantizer_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("midi_note_scale_quantizer_tb NOT OK");
		$finish;
	end

	// Result side: bursts of back-pressure while idling is enabled.
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!idle_on)
				stall_left = 0;
			else if (stall_left == 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 17);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// All tasks start and end just after a falling edge.
	task automatic offer_event(input logic [7:0] status, input logic [6:0] key,
	                           input logic [6:0] velocity, input logic [31:0] tick);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap      = $urandom_range(1, 17);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = status;
		s_tdata  = {2'b00, tick, velocity, key};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Unused upper bits of every register write but the low mask carry noise that the block must ignore.
	task automatic load_config(input cfg_t c);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_MASK_LOW, c.mask_low);
		write_reg(REG_MASK_HIGH, {junk[63], c.mask_high});
		write_reg(REG_LOWEST, {junk[63:7], c.lowest});
		write_reg(REG_HIGHEST, {junk[56:0], c.highest});
		write_reg(REG_TRANSPOSE, {junk[55:0], c.transpose});
		write_reg(REG_TICK_OFS, {junk[31:0], c.tick_offset});
		write_reg(REG_SPARE_LO, junk);
		write_reg(REG_SPARE_HI, ~junk);
		cfg_valid = 1'b0;
	endtask

	// Non-note requests leave nothing to wait for, so idle cycles follow the last outstanding result.
	task automatic wait_results_done();
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		cfg_t         c;
		logic [127:0] scale;
		logic [7:0]   st;
		int           mode;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset registers: empty mask, so the clamped key comes out as it is, or as the highest bound where it reaches it.
		offer_event(8'h90, 7'd60, 7'd100, 32'd0);
		offer_event(8'h80, 7'd127, 7'd1, 32'hFFFF_FFFF);
		offer_event(8'h9F, 7'd10, 7'd0, 32'd123);
		wait_results_done();

		// Major scale between 36 and 96.
		scale = '0;
		for (int n = 0; n < NOTE_COUNT; n++)
			scale[n] = MAJOR_CLASSES[n % 12];
		c.mask_low    = scale[63:0];
		c.mask_high   = scale[126:64];
		c.lowest      = 7'd36;
		c.highest     = 7'd96;
		c.transpose   = 8'd0;
		c.tick_offset = 32'hFFFF_FFFF;
		load_config(c);
		offer_event(8'h90, 7'd60, 7'd100, 32'd5);
		offer_event(8'h91, 7'd61, 7'd64, 32'd0);
		offer_event(8'h92, 7'd0, 7'd127, 32'd0);
		offer_event(8'h93, 7'd127, 7'd1, 32'd77);
		offer_event(8'h9F, 7'd70, 7'd0, 32'd9);
		offer_event(8'h85, 7'd66, 7'd0, 32'd1);
		offer_event(8'h8A, 7'd66, 7'd10, 32'hFFFF_FFFF);
		offer_event(8'h00, 7'd60, 7'd60, 32'd0);
		offer_event(8'h7F, 7'd60, 7'd60, 32'd0);
		offer_event(8'hA0, 7'd60, 7'd60, 32'd0);
		offer_event(8'hE3, 7'd60, 7'd60, 32'd0);
		offer_event(8'hF0, 7'd60, 7'd60, 32'd0);
		offer_event(8'hFF, 7'd127, 7'd127, 32'hFFFF_FFFF);
		wait_results_done();

		// Most negative transpose with the lowest bound above the highest.
		c.mask_low    = '1;
		c.mask_high   = '1;
		c.lowest      = 7'd100;
		c.highest     = 7'd50;
		c.transpose   = 8'h80;
		c.tick_offset = 32'h8000_0000;
		load_config(c);
		offer_event(8'h90, 7'd127, 7'd5, 32'h8000_0000);
		offer_event(8'h94, 7'd0, 7'd5, 32'd0);
		wait_results_done();

		// Only note 126 in the scale: largest transpose, then a key searched for from far below.
		c.mask_low    = '0;
		c.mask_high   = 63'd1 << 62;
		c.lowest      = 7'd0;
		c.highest     = 7'd127;
		c.transpose   = 8'd127;
		c.tick_offset = 32'h7FFF_FFFF;
		load_config(c);
		offer_event(8'h90, 7'd0, 7'd1, 32'd1);
		wait_results_done();
		c.transpose = 8'h9C;
		load_config(c);
		offer_event(8'h90, 7'd120, 7'd33, 32'd2);
		offer_event(8'h81, 7'd127, 7'd33, 32'd3);
		wait_results_done();

		for (int phase = 0; phase < 9; phase++) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0: begin
					c.mask_low  = {$urandom, $urandom};
					c.mask_high = 63'({$urandom, $urandom});
				end
				1: begin
					c.mask_low  = {$urandom, $urandom} & {$urandom, $urandom} &
					              {$urandom, $urandom};
					c.mask_high = 63'({$urandom, $urandom} & {$urandom, $urandom} &
					              {$urandom, $urandom});
				end
				2: begin
					scale = 128'd1 << $urandom_range(0, 127);
					c.mask_low  = scale[63:0];
					c.mask_high = scale[126:64];
				end
				default: begin
					c.mask_low  = '1;
					c.mask_high = '1;
				end
			endcase
			if ($urandom_range(0, 4) == 0) begin
				c.lowest  = 7'($urandom);
				c.highest = 7'($urandom);
			end else begin
				c.lowest  = 7'($urandom_range(0, 50));
				c.highest = 7'($urandom_range(70, 127));
			end
			if ($urandom_range(0, 2) == 0)
				c.transpose = 8'($urandom);
			else
				c.transpose = 8'(int'($urandom_range(0, 24)) - 12);
			c.tick_offset = $urandom;
			if (phase == 0) begin
				c.lowest      = 7'd0;
				c.highest     = 7'd127;
				c.transpose   = 8'd127;
				c.tick_offset = 32'h7FFF_FFFF;
			end else if (phase == 1) begin
				c.lowest      = 7'd127;
				c.highest     = 7'd0;
				c.transpose   = 8'h80;
				c.tick_offset = 32'h8000_0000;
			end
			if (phase == 8)
				idle_on = 1'b0;
			load_config(c);
			// Mostly note events on random channels, the rest arbitrary status bytes.
			repeat (120) begin
				if ($urandom_range(0, 3) != 0)
					st = {($urandom_range(0, 1) != 0) ? CMD_NOTE_ON : CMD_NOTE_OFF,
					      4'($urandom)};
				else
					st = 8'($urandom);
				offer_event(st, 7'($urandom),
				            ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom), $urandom);
			end
			wait_results_done();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("midi_note_scale_quantizer_tb OK");
		else
			$display("midi_note_scale_quantizer_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
rtl/mnsq_pkg.sv
rtl/mnsq_cfg.sv
rtl/mnsq_snap.sv
rtl/midi_note_scale_quantizer.sv
dv/midi_note_scale_quantizer_chk.sv
dv/midi_note_scale_quantizer_tb.sv
